// ----- design/uvd_pkg.sv -----
// uvd_pkg: shared constants, codes and types of the usb video packet deframer
// no dependencies; imported by every module of the block
`default_nettype none

package uvd_pkg;

	// stream framing
	localparam int LINE_BYTES    = 1440;
	localparam int FRAME_BYTES   = 691200;
	localparam int PAYLOAD_BYTES = 180;
	localparam logic [7:0] SYNC_BYTE = 8'h47;

	// field widths
	localparam int BYTE_W   = 8;
	localparam int WINDOW_W = 24;
	localparam int KIND_W   = 2;
	localparam int ADDR_W   = 20;
	localparam int TYPE_W   = 3;
	localparam int LINE_W   = 9;
	localparam int BLOCK_W  = 4;
	localparam int COUNT_W  = 8;
	localparam int BASE_W   = 21;
	// compare width: holds base plus one payload and the frame size
	localparam int CMP_W    = 23;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
	localparam logic [KIND_W-1:0] KIND_VIDEO  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_AUDIO  = 2'd2;

	// message types
	localparam logic [TYPE_W-1:0] TYPE_VIDEO = 3'd1;
	localparam logic [TYPE_W-1:0] TYPE_AUDIO = 3'd2;
	localparam logic [TYPE_W-1:0] TYPE_ERROR = 3'd5;

	// last payload index
	localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(PAYLOAD_BYTES - 1);

	// one result beat
	typedef struct packed {
		logic [KIND_W-1:0]  result_kind;
		logic [ADDR_W-1:0]  frame_address;
		logic [BYTE_W-1:0]  data_byte;
		logic [TYPE_W-1:0]  message_type;
		logic [LINE_W-1:0]  line_number;
		logic               field_parity;
		logic [BLOCK_W-1:0] block_number;
		logic               out_of_range;
	} result_t;

	// decoded header window
	typedef struct packed {
		logic [TYPE_W-1:0]  msg_type;
		logic [LINE_W-1:0]  line;
		logic               field;
		logic [BLOCK_W-1:0] block;
		logic               oor;
		logic [BASE_W-1:0]  base;
	} header_t;

	// handoff from the deframer to the result queue
	typedef struct packed {
		logic    push;
		result_t data;
	} push_t;

endpackage

`default_nettype wire

// ----- design/uvd_if.sv -----
// uvd_if: valid/ready channel interfaces of the deframer (stream, result, config)
// depends on uvd_pkg
`default_nettype none

// input byte channel
interface uvd_byte_if import uvd_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink   (input valid, input stream_byte, output ready);
endinterface

// result channel
interface uvd_result_if import uvd_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  result_kind;
	logic [ADDR_W-1:0]  frame_address;
	logic [BYTE_W-1:0]  data_byte;
	logic [TYPE_W-1:0]  message_type;
	logic [LINE_W-1:0]  line_number;
	logic               field_parity;
	logic [BLOCK_W-1:0] block_number;
	logic               out_of_range;

	modport source (output valid, input ready, output result_kind, output frame_address,
		output data_byte, output message_type, output line_number, output field_parity,
		output block_number, output out_of_range);
	modport sink (input valid, output ready, input result_kind, input frame_address,
		input data_byte, input message_type, input line_number, input field_parity,
		input block_number, input out_of_range);
endinterface

// configuration write channel
interface uvd_cfg_if;
	logic valid;
	logic ready;
	logic audio_enable;

	modport source (output valid, output audio_enable, input ready);
	modport sink   (input valid, input audio_enable, output ready);
endinterface

`default_nettype wire

// ----- design/uvd_header_decode.sv -----
// uvd_header_decode: splits the 24-bit header window into its fields,
// computes the frame base address and the range check; depends on uvd_pkg
`default_nettype none

module uvd_header_decode import uvd_pkg::*; (
	input  wire logic [WINDOW_W-1:0] window,
	output header_t                  hdr
);

	logic [LINE_W-1:0]  line;
	logic               field;
	logic [BLOCK_W-1:0] block;
	logic [BASE_W-1:0]  pos;
	logic [CMP_W-1:0]   pos_end;
	logic               oor;

	// header bit fields
	assign block = window[10:7];
	assign field = window[11];
	assign line  = window[20:12];

	// base = (line*2 + field)*line bytes + block*payload bytes
	assign pos = BASE_W'({line, field}) * BASE_W'(LINE_BYTES)
		+ BASE_W'(block) * BASE_W'(PAYLOAD_BYTES);

	// range check against the frame store
	assign pos_end = CMP_W'(pos) + CMP_W'(PAYLOAD_BYTES);
	assign oor     = (pos_end > CMP_W'(FRAME_BYTES));

	always_comb begin
		hdr.msg_type = oor ? TYPE_ERROR : window[23:21];
		hdr.line     = line;
		hdr.field    = field;
		hdr.block    = block;
		hdr.oor      = oor;
		hdr.base     = pos;
	end

endmodule

`default_nettype wire

// ----- design/uvd_deframe_core.sv -----
// uvd_deframe_core: input register, sync hunt and payload state, result forming
// depends on uvd_pkg and uvd_header_decode
`default_nettype none

module uvd_deframe_core import uvd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [BYTE_W-1:0] in_byte,
	output logic                   in_ready,
	input  wire logic              audio_enable,
	input  wire logic              space,
	output push_t                  push_out
);

	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic [WINDOW_W-1:0] window_q;
	logic                in_payload_q;
	logic [COUNT_W-1:0]  count_q;
	logic [TYPE_W-1:0]   type_q;
	logic [BASE_W-1:0]   base_q;

	header_t hdr;
	logic    is_sync;
	logic    has_result;
	logic    go;
	logic    last_beat;
	result_t res;

	uvd_header_decode u_decode (
		.window (window_q),
		.hdr    (hdr)
	);

	assign is_sync   = (byte_s1 == SYNC_BYTE);
	assign last_beat = (count_q == LAST_COUNT);

	// result of the byte held in stage one
	always_comb begin
		res        = '0;
		has_result = 1'b0;
		if (!in_payload_q) begin
			if (is_sync) begin
				has_result       = 1'b1;
				res.result_kind  = KIND_HEADER;
				res.message_type = hdr.msg_type;
				res.line_number  = hdr.line;
				res.field_parity = hdr.field;
				res.block_number = hdr.block;
				res.out_of_range = hdr.oor;
			end
		end else if (type_q == TYPE_VIDEO) begin
			has_result        = 1'b1;
			res.result_kind   = KIND_VIDEO;
			res.frame_address = ADDR_W'(base_q + BASE_W'(count_q));
			res.data_byte     = byte_s1;
			res.message_type  = type_q;
		end else if (type_q == TYPE_AUDIO && audio_enable) begin
			has_result       = 1'b1;
			res.result_kind  = KIND_AUDIO;
			res.data_byte    = byte_s1;
			res.message_type = type_q;
		end
	end

	// stage one moves on unless its result finds the queue full
	assign go       = valid_s1 && (!has_result || space);
	assign in_ready = !valid_s1 || go;

	assign push_out.push = go && has_result;
	assign push_out.data = res;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	// hunt and payload state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= '0;
			in_payload_q <= 1'b0;
			count_q      <= '0;
			type_q       <= '0;
			base_q       <= '0;
		end else if (go) begin
			if (!in_payload_q) begin
				if (is_sync) begin
					in_payload_q <= 1'b1;
					count_q      <= '0;
					type_q       <= hdr.msg_type;
					base_q       <= hdr.base;
				end else begin
					window_q <= {byte_s1, window_q[WINDOW_W-1:BYTE_W]};
				end
			end else if (last_beat) begin
				in_payload_q <= 1'b0;
				count_q      <= '0;
				window_q     <= '0;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// payload count stays inside one packet
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LAST_COUNT)
		else $error("payload count beyond packet length");

	// sync while hunting opens a payload
	a_sync_opens: assert property (@(posedge clk) disable iff (!arst_n)
		go && !in_payload_q && is_sync |=> in_payload_q && count_q == '0)
		else $error("sync did not open a payload");

	// last payload byte returns to hunting with a clean window
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		go && in_payload_q && last_beat |=> !in_payload_q && window_q == '0)
		else $error("payload end did not clear the hunt state");

endmodule

`default_nettype wire

// ----- design/uvd_result_queue.sv -----
// uvd_result_queue: two-entry result buffer that parts the deframer from the
// result receiver; depends on uvd_pkg
`default_nettype none

module uvd_result_queue import uvd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  push_t     push_in,
	output logic      space,
	output logic      out_valid,
	input  wire logic out_ready,
	output result_t   out_data
);

	result_t    entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       pop;

	assign space     = (fill_q != 2'd2);
	assign out_valid = (fill_q != 2'd0);
	assign out_data  = entry_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (push_in.push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push_in.push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push_in.push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push_in.push) begin
			entry_q[wr_ptr_q] <= push_in.data;
		end
	end

	// no write into a full buffer
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_in.push |-> fill_q != 2'd2)
		else $error("result pushed into a full buffer");

	// pointers differ exactly when one entry is held
	a_ptr_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q != rd_ptr_q) == (fill_q == 2'd1))
		else $error("buffer pointers disagree with fill level");

endmodule

`default_nettype wire

// ----- design/usb_video_packet_deframer.sv -----
// usb_video_packet_deframer: top level of the usb capture stream deframer
// depends on uvd_pkg, uvd_if, uvd_deframe_core and uvd_result_queue
//
// Usage:
//   stream carries one raw byte per beat. While hunting, the block keeps the
//   three bytes before the current one as a header and waits for sync 0x47;
//   on sync it returns one header report beat, then treats the next 180 bytes
//   as payload. Video payload bytes come back as frame store writes, audio
//   bytes come back only while audio_enable is set, other payload is dropped.
//   cfg writes audio_enable; it is always ready. The user must write it only
//   while idle; the block itself does not enforce it. Throughput is one stream
//   byte per cycle unless a byte's result finds the output buffer full. A byte
//   accepted is held in the input register; its result is written into a
//   two-entry output buffer and offered on result straight from there.
//   When the receiver stalls, the buffer absorbs two results; stream ready
//   then drops only when the byte in the input register produces a result.
//   Reset clears the hunt state, the window, the buffer and audio_enable.
`default_nettype none

module usb_video_packet_deframer import uvd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	uvd_cfg_if.sink       cfg,
	uvd_byte_if.sink      stream,
	uvd_result_if.source  result
);

	logic    audio_enable_q;
	logic    space;
	push_t   push;
	result_t out_data;

	// configuration register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			audio_enable_q <= 1'b0;
		end else if (cfg.valid) begin
			audio_enable_q <= cfg.audio_enable;
		end
	end

	uvd_deframe_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (stream.valid),
		.in_byte      (stream.stream_byte),
		.in_ready     (stream.ready),
		.audio_enable (audio_enable_q),
		.space        (space),
		.push_out     (push)
	);

	uvd_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_in   (push),
		.space     (space),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (out_data)
	);

	// result beat fields
	assign result.result_kind   = out_data.result_kind;
	assign result.frame_address = out_data.frame_address;
	assign result.data_byte     = out_data.data_byte;
	assign result.message_type  = out_data.message_type;
	assign result.line_number   = out_data.line_number;
	assign result.field_parity  = out_data.field_parity;
	assign result.block_number  = out_data.block_number;
	assign result.out_of_range  = out_data.out_of_range;

endmodule

`default_nettype wire

// ----- sim/deframe_scoreboard_pkg.sv -----
// deframe_scoreboard_pkg: byte-level predictor and result scoreboard for the deframer bench
// depends on uvd_pkg for widths, codes and the result beat type
package deframe_scoreboard_pkg;
	import uvd_pkg::*;

	class deframe_scoreboard;
		// results the deframer still owes, oldest first
		result_t              pending_beats[$];
		int unsigned          errors;

		// shadow of the deframer state and its register
		logic                 audio_enable;
		logic [WINDOW_W-1:0]  header_window;
		logic                 in_payload;
		logic [COUNT_W-1:0]   payload_count;
		logic [TYPE_W-1:0]    current_type;
		logic [BASE_W-1:0]    base_address;

		function new();
			errors = 0;
			audio_enable = 1'b0;
			header_window = '0;
			in_payload = 1'b0;
			payload_count = '0;
			current_type = '0;
			base_address = '0;
		endfunction

		function int pending();
			return pending_beats.size();
		endfunction

		// one line per mismatch
		task report(input string msg);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		// advance the shadow state by one accepted stream beat
		function void note_stream_byte(input logic [BYTE_W-1:0] b);
			result_t            beat;
			logic [BLOCK_W-1:0] blk;
			logic               fld;
			logic [LINE_W-1:0]  ln;
			logic [TYPE_W-1:0]  ty;
			logic               oor;
			int                 base;
			logic [BASE_W-1:0]  addr;

			beat = '0;
			if (!in_payload) begin
				// hunting: shift non-sync bytes into the header window
				if (b != SYNC_BYTE) begin
					header_window = {b, header_window[WINDOW_W-1:8]};
					return;
				end
				blk = header_window[10:7];
				fld = header_window[11];
				ln  = header_window[20:12];
				ty  = header_window[23:21];
				base = (int'(ln) * 2 + int'(fld)) * LINE_BYTES + int'(blk) * PAYLOAD_BYTES;
				oor = (base + PAYLOAD_BYTES > FRAME_BYTES);
				if (oor)
					ty = TYPE_ERROR;
				current_type = ty;
				base_address = base[BASE_W-1:0];
				in_payload = 1'b1;
				payload_count = '0;
				beat.result_kind = KIND_HEADER;
				beat.message_type = ty;
				beat.line_number = ln;
				beat.field_parity = fld;
				beat.block_number = blk;
				beat.out_of_range = oor;
				pending_beats.push_back(beat);
				return;
			end

			// payload: video writes, audio when enabled, the rest dropped
			if (current_type == TYPE_VIDEO) begin
				addr = base_address + BASE_W'(payload_count);
				beat.result_kind = KIND_VIDEO;
				beat.frame_address = addr[ADDR_W-1:0];
				beat.data_byte = b;
				beat.message_type = current_type;
				pending_beats.push_back(beat);
			end else if (current_type == TYPE_AUDIO && audio_enable) begin
				beat.result_kind = KIND_AUDIO;
				beat.data_byte = b;
				beat.message_type = current_type;
				pending_beats.push_back(beat);
			end
			payload_count = payload_count + 1'b1;
			if (payload_count >= PAYLOAD_BYTES) begin
				in_payload = 1'b0;
				payload_count = '0;
				header_window = '0;
			end
		endfunction

		task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
			if (got !== want)
				report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
		endtask

		// compare one accepted result beat with the oldest expectation
		task check_result_beat(input result_t got);
			result_t want;

			if (pending_beats.size() == 0) begin
				report($sformatf("result beat kind %0d with nothing expected", got.result_kind));
				return;
			end
			want = pending_beats.pop_front();
			compare_field("result_kind", 32'(got.result_kind), 32'(want.result_kind));
			compare_field("frame_address", 32'(got.frame_address), 32'(want.frame_address));
			compare_field("data_byte", 32'(got.data_byte), 32'(want.data_byte));
			compare_field("message_type", 32'(got.message_type), 32'(want.message_type));
			compare_field("line_number", 32'(got.line_number), 32'(want.line_number));
			compare_field("field_parity", 32'(got.field_parity), 32'(want.field_parity));
			compare_field("block_number", 32'(got.block_number), 32'(want.block_number));
			compare_field("out_of_range", 32'(got.out_of_range), 32'(want.out_of_range));
		endtask

		// anything still owed at the end is a failure
		task check_drained();
			if (pending_beats.size() != 0)
				report($sformatf("%0d expected result beats never arrived", pending_beats.size()));
		endtask
	endclass

endpackage

// ----- sim/testbench.sv -----
// testbench: drives byte streams of framed and broken packets into the deframer
// and checks every result beat; depends on uvd_pkg, uvd_if and deframe_scoreboard_pkg
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import uvd_pkg::*;
	import deframe_scoreboard_pkg::*;

	// message type without a name in the design package
	localparam logic [TYPE_W-1:0] TYPE_VBI = 3'd3;

	localparam int DRAIN_CYCLES = 8;
	localparam int ITEM_TARGET  = 1450;
	localparam int CYCLE_LIMIT  = 600000;

	logic clk;
	logic arst_n;

	uvd_byte_if   stream_if ();
	uvd_result_if result_if ();
	uvd_cfg_if    cfg_if ();

	usb_video_packet_deframer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.stream (stream_if),
		.result (result_if)
	);

	deframe_scoreboard sb;
	bit src_burst;
	bit rcv_burst;
	int bytes_sent;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// one stream beat, after a random gap
	task send_byte(input logic [BYTE_W-1:0] b);
		int gap;

		gap = src_burst ? 0 : $urandom_range(0, 6);
		if ($urandom_range(0, 29) == 0)
			src_burst = !src_burst;
		if (gap > 0) begin
			stream_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stream_if.valid <= 1'b1;
		stream_if.stream_byte <= b;
		do @(posedge clk); while (!stream_if.ready);
		sb.note_stream_byte(b);
		bytes_sent++;
	endtask

	// stop sending until every owed result is back and the pipe is empty
	task hold_until_drained();
		stream_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task write_audio_enable(input logic value);
		hold_until_drained();
		cfg_if.valid <= 1'b1;
		cfg_if.audio_enable <= value;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		sb.audio_enable = value;
	endtask

	// payload bytes lean on sync and the byte extremes
	function logic [BYTE_W-1:0] payload_byte();
		int pick;

		pick = $urandom_range(0, 15);
		if (pick == 0)
			return SYNC_BYTE;
		if (pick == 1)
			return 8'h00;
		if (pick == 2)
			return 8'hff;
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	// finish any open payload, then header, sync and a full payload
	task send_packet(input logic [TYPE_W-1:0] ty, input logic [LINE_W-1:0] ln,
		input logic fld, input logic [BLOCK_W-1:0] blk);
		logic [WINDOW_W-1:0] hdr;
		int i;

		while (sb.in_payload)
			send_byte(payload_byte());
		hdr = {ty, ln, fld, blk, 7'($urandom)};
		send_byte(hdr[7:0]);
		send_byte(hdr[15:8]);
		send_byte(hdr[23:16]);
		send_byte(SYNC_BYTE);
		for (i = 0; i < PAYLOAD_BYTES; i++)
			send_byte(payload_byte());
	endtask

	// result sink with random stalls
	initial begin
		result_t got;
		int stall;

		result_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rcv_burst ? 0 : $urandom_range(0, 6);
			if ($urandom_range(0, 29) == 0)
				rcv_burst = !rcv_burst;
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!result_if.valid);
			got.result_kind   = result_if.result_kind;
			got.frame_address = result_if.frame_address;
			got.data_byte     = result_if.data_byte;
			got.message_type  = result_if.message_type;
			got.line_number   = result_if.line_number;
			got.field_parity  = result_if.field_parity;
			got.block_number  = result_if.block_number;
			got.out_of_range  = result_if.out_of_range;
			sb.check_result_beat(got);
		end
	end

	// stimulus
	initial begin
		int pick;
		int n;
		int i;
		logic [TYPE_W-1:0] ty;
		logic [LINE_W-1:0] ln;

		sb = new();
		src_burst = 1'b0;
		bytes_sent = 0;
		arst_n <= 1'b0;
		stream_if.valid <= 1'b0;
		stream_if.stream_byte <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.audio_enable <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: byte extremes while hunting, near-sync values
		write_audio_enable(1'b0);
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(SYNC_BYTE - 8'd1);
		send_byte(SYNC_BYTE + 8'd1);
		// first block of the frame, last block that fits, one past it
		send_packet(TYPE_VIDEO, 9'd0, 1'b0, 4'd0);
		send_packet(TYPE_VIDEO, 9'd239, 1'b1, 4'd7);
		send_packet(TYPE_VIDEO, 9'd239, 1'b1, 4'd8);
		// audio while disabled, then enabled
		send_packet(TYPE_AUDIO, 9'd17, 1'b0, 4'd3);
		write_audio_enable(1'b1);
		send_packet(TYPE_AUDIO, 9'd0, 1'b1, 4'd15);
		// silent type with the largest header fields, out of range
		send_packet(TYPE_VBI, 9'd511, 1'b1, 4'd15);
		write_audio_enable(1'b0);

		// random: mostly framed packets, some noise, short windows, pauses
		while (bytes_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 19);
			if (pick < 12) begin
				n = $urandom_range(0, 9);
				if (n < 6)
					ty = TYPE_VIDEO;
				else if (n < 8)
					ty = TYPE_AUDIO;
				else
					ty = TYPE_W'($urandom_range(0, 7));
				ln = ($urandom_range(0, 3) == 0) ? LINE_W'($urandom_range(0, 511))
					: LINE_W'($urandom_range(0, 239));
				send_packet(ty, ln, 1'($urandom_range(0, 1)), BLOCK_W'($urandom_range(0, 15)));
			end else if (pick < 16) begin
				// noise burst, now and then carrying a stray sync
				n = $urandom_range(1, 10);
				for (i = 0; i < n; i++)
					send_byte(($urandom_range(0, 7) == 0) ? SYNC_BYTE
						: BYTE_W'($urandom_range(0, 255)));
			end else if (pick < 18) begin
				// sync with fewer than three bytes since the hunt began
				while (sb.in_payload)
					send_byte(payload_byte());
				n = $urandom_range(0, 2);
				for (i = 0; i < n; i++)
					send_byte(BYTE_W'($urandom_range(0, 255)));
				send_byte(SYNC_BYTE);
			end else if (pick == 18) begin
				hold_until_drained();
			end else begin
				write_audio_enable(1'($urandom_range(0, 1)));
			end
		end

		// wait out every owed result and the pipeline
		hold_until_drained();
		sb.check_drained();
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
